### hdl/mcr_pkg.sv
// Shared constants for the midpoint circle rasterizer.
package mcr_pkg;

  // Default field widths.
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;

  // Command codes carried in the action field.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Octant indexes within one iteration.
  localparam logic [2:0] OCT_FIRST = 3'd0;
  localparam logic [2:0] OCT_LAST  = 3'd7;

  // Depth of the record queue between front and back.
  localparam int QUEUE_DEPTH = 2;

endpackage

### hdl/mcr_if.sv
// Channel interfaces for commands in and plotted points out.
interface mcr_cmd_if #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, action, center_x, center_y, radius, input ready);
  modport sink   (input valid, action, center_x, center_y, radius, output ready);
endinterface

interface mcr_pts_if #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] point_x;
  logic signed [COORD_BITS+1:0] point_y;
  logic [2:0]                   octant;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, point_x, point_y, octant, last_of_step, circle_done,
                  input ready);
  modport sink   (input valid, point_x, point_y, octant, last_of_step, circle_done,
                  output ready);
endinterface

### hdl/mcr_front.sv
// Front end: takes commands, runs one walk iteration for each that plots, and queues step records.
module mcr_front #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int REC_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  logic             clk,
  input  logic             rst,
  mcr_cmd_if.sink          cmd,
  output logic             rec_valid,
  output logic [REC_W-1:0] rec_data,
  input  logic             rec_full
);

  localparam int XW = RADIUS_BITS + 2;  // walk coordinates
  localparam int SW = RADIUS_BITS + 3;  // step increments
  localparam int EW = RADIUS_BITS + 4;  // decision term

  // Walk state.
  logic signed [XW-1:0]   cur_x, cur_y;
  logic signed [SW-1:0]   step_x, step_y;
  logic signed [EW-1:0]   error_term;
  logic [COORD_BITS-1:0]  held_center_x, held_center_y;
  logic [RADIUS_BITS-1:0] held_radius;
  logic                   drawing;

  // Values the iteration starts from: fresh on a start, held otherwise.
  logic                   is_start, accept;
  logic signed [XW-1:0]   base_x, base_y;
  logic signed [SW-1:0]   base_dx, base_dy;
  logic signed [EW-1:0]   base_err, two_r;
  logic [COORD_BITS-1:0]  base_cx, base_cy;
  logic [RADIUS_BITS-1:0] base_r;
  logic                   base_draw;

  // Iteration results.
  logic signed [XW-1:0]   x_next, y_next;
  logic signed [SW-1:0]   dx_next, dy_next;
  logic signed [EW-1:0]   err_next;
  logic                   done;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !rec_full;
  assign is_start  = (cmd.action == mcr_pkg::ACT_START);

  // Select the state the iteration works from.
  always_comb begin
    if (is_start) begin
      base_r    = cmd.radius;
      base_cx   = cmd.center_x;
      base_cy   = cmd.center_y;
      base_x    = $signed({2'b00, cmd.radius}) - XW'(1);
      base_y    = '0;
      base_dx   = SW'(1);
      base_dy   = SW'(1);
      base_err  = EW'(1) - $signed({3'b000, cmd.radius, 1'b0});
      base_draw = (cmd.radius != '0);
    end else begin
      base_r    = held_radius;
      base_cx   = held_center_x;
      base_cy   = held_center_y;
      base_x    = cur_x;
      base_y    = cur_y;
      base_dx   = step_x;
      base_dy   = step_y;
      base_err  = error_term;
      base_draw = drawing;
    end
  end

  assign two_r = $signed({3'b000, base_r, 1'b0});

  // One axis move per iteration, chosen by the sign of the decision term.
  always_comb begin
    x_next   = base_x;
    y_next   = base_y;
    dx_next  = base_dx;
    dy_next  = base_dy;
    if (base_err <= 0) begin
      y_next   = base_y + XW'(1);
      err_next = base_err + EW'(base_dy);
      dy_next  = base_dy + SW'(2);
    end else begin
      x_next   = base_x - XW'(1);
      dx_next  = base_dx + SW'(2);
      err_next = base_err + EW'(base_dx + SW'(2)) - two_r;
    end
    done = (x_next < y_next);
  end

  // State update on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      step_x        <= SW'(1);
      step_y        <= SW'(1);
      error_term    <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      drawing       <= 1'b0;
    end else if (accept) begin
      held_center_x <= base_cx;
      held_center_y <= base_cy;
      held_radius   <= base_r;
      if (base_draw) begin
        cur_x      <= x_next;
        cur_y      <= y_next;
        step_x     <= dx_next;
        step_y     <= dy_next;
        error_term <= err_next;
        drawing    <= !done;
      end else begin
        cur_x      <= base_x;
        cur_y      <= base_y;
        step_x     <= base_dx;
        step_y     <= base_dy;
        error_term <= base_err;
        drawing    <= 1'b0;
      end
    end
  end

  // The record carries the pre-move coordinates that the eight points use.
  assign rec_valid = accept && base_draw;
  assign rec_data  = {done, base_y, base_x, base_cy, base_cx};

endmodule

### hdl/mcr_queue.sv
// Short FIFO of step records between front and back.
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Storage writes need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("record pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty)) else $error("record popped from empty queue");

endmodule

### hdl/mcr_back.sv
// Back end: turns each step record into eight mirrored points, one per cycle while pts.ready is high.
module mcr_back #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int REC_W       = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rec_valid,
  input  logic [REC_W-1:0] rec_data,
  output logic             rec_pop,
  mcr_pts_if.source        pts
);

  localparam int XW    = RADIUS_BITS + 2;
  localparam int OW    = COORD_BITS + 2;
  localparam int WIDER = (COORD_BITS > XW) ? COORD_BITS : XW;
  localparam int PW    = WIDER + 2;

  // Record being drawn.
  logic                  busy;
  logic [2:0]            octant;
  logic [COORD_BITS-1:0] cx, cy;
  logic signed [XW-1:0]  px, py;
  logic                  rec_done;

  logic                  out_accept, last;
  logic                  swap, neg_x, neg_y;
  logic signed [XW-1:0]  off_x, off_y;
  logic signed [PW-1:0]  sum_x, sum_y;

  assign out_accept = pts.valid && pts.ready;
  assign last       = (octant == mcr_pkg::OCT_LAST);
  assign rec_pop    = rec_valid && (!busy || (out_accept && last));

  // Load a record or advance through its octants.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      octant <= mcr_pkg::OCT_FIRST;
    end else if (rec_pop) begin
      busy   <= 1'b1;
      octant <= mcr_pkg::OCT_FIRST;
    end else if (out_accept) begin
      busy   <= !last;
      octant <= octant + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      {rec_done, py, px, cy, cx} <= rec_data;
    end
  end

  // Octants 1, 2, 5 and 6 swap the axes; 2 to 5 mirror x, 4 to 7 mirror y.
  always_comb begin
    swap  = (octant == 3'd1) || (octant == 3'd2) || (octant == 3'd5) || (octant == 3'd6);
    neg_x = (octant == 3'd2) || (octant == 3'd3) || (octant == 3'd4) || (octant == 3'd5);
    neg_y = octant[2];
    off_x = swap ? py : px;
    off_y = swap ? px : py;
    sum_x = neg_x ? $signed({{(PW - COORD_BITS){1'b0}}, cx}) - PW'(off_x)
                  : $signed({{(PW - COORD_BITS){1'b0}}, cx}) + PW'(off_x);
    sum_y = neg_y ? $signed({{(PW - COORD_BITS){1'b0}}, cy}) - PW'(off_y)
                  : $signed({{(PW - COORD_BITS){1'b0}}, cy}) + PW'(off_y);
  end

  assign pts.valid        = busy;
  assign pts.point_x      = sum_x[OW-1:0];
  assign pts.point_y      = sum_y[OW-1:0];
  assign pts.octant       = octant;
  assign pts.last_of_step = last;
  assign pts.circle_done  = last && rec_done;

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    pts.valid && pts.circle_done |-> pts.last_of_step)
    else $error("circle_done off the last point");
  a_octant_wraps: assert property (@(posedge clk) disable iff (rst)
    out_accept && last |=> !pts.valid || pts.octant == mcr_pkg::OCT_FIRST)
    else $error("new record does not start at the first octant");
  a_octant_advances: assert property (@(posedge clk) disable iff (rst)
    out_accept && !last |=> pts.valid && pts.octant == $past(octant) + 3'd1)
    else $error("octant did not advance after a transaction");

endmodule

### hdl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer.
//
//   Channel  Dir  Payload                                            Transaction
//   cmd      in   action, center_x, center_y, radius                 valid & ready
//   pts      out  point_x, point_y, octant, last_of_step, circle_done valid & ready
//
// Each command runs one iteration in the front end in the cycle it is taken.
// An iteration that plots yields eight points, one per cycle while pts.ready is high, so
// the sustained step rate is set by the single point adder pair in the back end.
// Commands that plot nothing (idle step, zero radius) push no record.
// The front end keeps taking commands while the two-entry record queue has room.
// Reset is synchronous and clears the walk state, queue and octant counter.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mcr_cmd_if.sink   cmd,
  mcr_pts_if.source pts
);

  localparam int REC_W = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1;

  logic             push, full, pop, not_empty;
  logic [REC_W-1:0] push_data, head;

  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rec_valid(push),
    .rec_data (push_data),
    .rec_full (full)
  );

  mcr_queue #(
    .WIDTH(REC_W),
    .DEPTH(mcr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .not_empty(not_empty),
    .head     (head)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(not_empty),
    .rec_data (head),
    .rec_pop  (pop),
    .pts      (pts)
  );

endmodule

### tb/tb_midpoint_circle_rasterizer.sv
// Self-checking testbench for the midpoint circle rasterizer, with a built-in point predictor.
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;

  localparam int CW = mcr_pkg::COORD_BITS_DEF;
  localparam int RW = mcr_pkg::RADIUS_BITS_DEF;
  localparam int OW = CW + 2;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 280;

  // One plotted point as it leaves the block.
  typedef struct packed {
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] py;
    logic [2:0]           oct;
    logic                 last;
    logic                 done;
  } point_t;

  // Tracks the circle walk and holds the points still owed by the block.
  class circle_scoreboard;
    int      walk_x, walk_y, err, step_x, step_y;
    int      ctr_x, ctr_y, rad;
    bit      drawing;
    int      failures;
    point_t  owed_points[$];

    function new();
      walk_x = 0; walk_y = 0; err = 0; step_x = 1; step_y = 1;
      ctr_x = 0; ctr_y = 0; rad = 0;
      drawing = 0;
      failures = 0;
    endfunction

    function int pending();
      return owed_points.size();
    endfunction

    // Runs one iteration for an accepted command; returns the number of points it owes.
    function int note_command(logic act, logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [RW-1:0] r);
      int     x, y, ox, oy;
      bit     fin;
      point_t pt;
      if (act == mcr_pkg::ACT_START) begin
        ctr_x = int'(cx);
        ctr_y = int'(cy);
        rad = int'(r);
        walk_x = rad - 1;
        walk_y = 0;
        step_x = 1;
        step_y = 1;
        err = 1 - 2 * rad;
        drawing = (walk_x >= walk_y);
      end
      if (!drawing) return 0;

      x = walk_x;
      y = walk_y;
      // A single move per iteration, along y or along x.
      if (err <= 0) begin
        walk_y = walk_y + 1;
        err = err + step_y;
        step_y = step_y + 2;
      end else begin
        walk_x = walk_x - 1;
        step_x = step_x + 2;
        err = err + step_x - 2 * rad;
      end
      fin = (walk_x < walk_y);
      if (fin) drawing = 0;

      // Eight mirrored points in the fixed plotting order.
      for (int k = 0; k < 8; k++) begin
        case (k)
          0: begin ox = x;  oy = y;  end
          1: begin ox = y;  oy = x;  end
          2: begin ox = -y; oy = x;  end
          3: begin ox = -x; oy = y;  end
          4: begin ox = -x; oy = -y; end
          5: begin ox = -y; oy = -x; end
          6: begin ox = y;  oy = -x; end
          default: begin ox = x; oy = -y; end
        endcase
        pt.px = OW'(ctr_x + ox);
        pt.py = OW'(ctr_y + oy);
        pt.oct = 3'(k);
        pt.last = (pt.oct == mcr_pkg::OCT_LAST);
        pt.done = pt.last && fin;
        owed_points.push_back(pt);
      end
      return 8;
    endfunction

    // Compares one accepted point with the oldest owed point.
    function void check_point(point_t got);
      point_t exp_pt;
      if (owed_points.size() == 0) begin
        $display("%0t: unexpected point: expected none, actual x=%0d y=%0d oct=%0d",
                 $time, got.px, got.py, got.oct);
        failures++;
        return;
      end
      exp_pt = owed_points.pop_front();
      if (got.px !== exp_pt.px) begin
        $display("%0t: point_x mismatch: expected %0d, actual %0d", $time, exp_pt.px, got.px);
        failures++;
      end
      if (got.py !== exp_pt.py) begin
        $display("%0t: point_y mismatch: expected %0d, actual %0d", $time, exp_pt.py, got.py);
        failures++;
      end
      if (got.oct !== exp_pt.oct) begin
        $display("%0t: octant mismatch: expected %0d, actual %0d", $time, exp_pt.oct, got.oct);
        failures++;
      end
      if (got.last !== exp_pt.last) begin
        $display("%0t: last_of_step mismatch: expected %0b, actual %0b",
                 $time, exp_pt.last, got.last);
        failures++;
      end
      if (got.done !== exp_pt.done) begin
        $display("%0t: circle_done mismatch: expected %0b, actual %0b",
                 $time, exp_pt.done, got.done);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   useful_items;
  int   stall_cycles;

  circle_scoreboard sb;

  mcr_cmd_if cmd_ch ();
  mcr_pts_if pts_ch ();

  midpoint_circle_rasterizer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pts (pts_ch)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Point receiver: stalls at random except during the calm stretch.
  always @(posedge clk) begin
    pts_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Checks every accepted point.
  always @(posedge clk) begin
    if (!rst && pts_ch.valid && pts_ch.ready) begin
      sb.check_point('{pts_ch.point_x, pts_ch.point_y, pts_ch.octant,
                       pts_ch.last_of_step, pts_ch.circle_done});
    end
  end

  // Watchdog on cycles in which no transaction takes place.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pts_ch.valid && pts_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one command, waits for its transaction and records it.
  task automatic push_command(logic act, logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [RW-1:0] r);
    int owed;
    while (!calm && $urandom_range(0, 99) < 36) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.action   <= act;
    cmd_ch.center_x <= cx;
    cmd_ch.center_y <= cy;
    cmd_ch.radius   <= r;
    do @(posedge clk); while (!cmd_ch.ready);
    owed = sb.note_command(act, cx, cy, r);
    if (act == mcr_pkg::ACT_START || owed > 0) useful_items++;
  endtask

  // Starts a circle and steps it until it finishes or max_steps is reached.
  task automatic run_circle(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [RW-1:0] r,
                            int max_steps);
    int steps;
    steps = 0;
    push_command(mcr_pkg::ACT_START, cx, cy, r);
    while (sb.drawing && steps < max_steps) begin
      push_command(mcr_pkg::ACT_STEP, CW'($urandom), CW'($urandom), RW'($urandom));
      steps++;
    end
  endtask

  initial begin
    int  pick;
    int  r;
    int  limit;
    bit  drained;
    sb = new();
    calm = 1'b0;
    drained = 1'b0;
    useful_items = 0;
    rst <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.action   <= mcr_pkg::ACT_STEP;
    cmd_ch.center_x <= '0;
    cmd_ch.center_y <= '0;
    cmd_ch.radius   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle step, zero radius, one-iteration circle, step after the end.
    push_command(mcr_pkg::ACT_STEP, '1, '1, '1);
    push_command(mcr_pkg::ACT_START, '0, '0, '0);
    run_circle(12'd2048, 12'd2048, 11'd1, 8);
    push_command(mcr_pkg::ACT_STEP, '0, '0, '0);
    // Largest radius at both corners; the second start abandons the first circle.
    run_circle('0, '0, '1, 3);
    run_circle('1, '1, '1, 3);
    push_command(mcr_pkg::ACT_STEP, '0, '0, '0);
    // Small circles run to completion near opposite corners.
    run_circle('1, '0, 11'd2, 64);
    run_circle('0, '1, 11'd3, 64);
    push_command(mcr_pkg::ACT_STEP, '1, '1, '1);

    // Random: mostly well-formed circles, some abandoned, plus noise commands.
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      calm = (useful_items >= 60 && useful_items < 130);
      if (!drained && useful_items >= 150) begin
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 99) < 85) begin
          r = $urandom_range(1, 30);
          limit = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 5) : 4096;
        end else begin
          r = $urandom_range(31, (1 << RW) - 1);
          limit = $urandom_range(0, 10);
        end
        run_circle(CW'($urandom_range(0, (1 << CW) - 1)),
                   CW'($urandom_range(0, (1 << CW) - 1)), RW'(r), limit);
        if ($urandom_range(0, 99) < 20) begin
          push_command(mcr_pkg::ACT_STEP, CW'($urandom), CW'($urandom), RW'($urandom));
        end
      end else if (pick < 90) begin
        push_command(mcr_pkg::ACT_START, CW'($urandom), CW'($urandom), '0);
      end else begin
        push_command(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                     RW'($urandom));
      end
    end
    calm = 1'b0;
    cmd_ch.valid <= 1'b0;

    // Drain, then allow a few more cycles for any stray point.
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### midpoint_circle_rasterizer.f
hdl/mcr_pkg.sv
hdl/mcr_if.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer.sv
tb/tb_midpoint_circle_rasterizer.sv
